// ===== sv/b64dec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64dec_pkg
// Types, constants and the character classifier shared by the base64 decoder.
// ----------------------------------------------------------------------------
package b64dec_pkg;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;  // '='
    localparam logic [7:0] PLUS_CHAR   = 8'h2B;  // '+'
    localparam logic [7:0] SLASH_CHAR  = 8'h2F;  // '/'
    localparam logic [5:0] LOWER_BASE  = 6'd26;
    localparam logic [5:0] DIGIT_BASE  = 6'd52;
    localparam logic [5:0] PLUS_VALUE  = 6'd62;
    localparam logic [5:0] SLASH_VALUE = 6'd63;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_input;
    } b64_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       end_of_message;
        logic       lone_sextet_error;
    } b64_out_t;

    // One queued request: up to three bytes, most significant first.
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  nbytes;
        logic        eom;
        logic        err;
    } b64_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } b64_fifo_stat_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } b64_sextet_t;

    function automatic b64_sextet_t char_decode(input logic [7:0] c);
        b64_sextet_t r;
        logic [7:0]  d;
        r.hit   = 1'b1;
        r.value = '0;
        d       = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            d       = c - 8'h41;
            r.value = d[5:0];
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            d       = c - 8'h61;
            r.value = d[5:0] + LOWER_BASE;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            d       = c - 8'h30;
            r.value = d[5:0] + DIGIT_BASE;
        end
        else if (c == PLUS_CHAR)
        begin
            r.value = PLUS_VALUE;
        end
        else if (c == SLASH_CHAR)
        begin
            r.value = SLASH_VALUE;
        end
        else
        begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/b64dec_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64dec_front
// Classifies characters, packs sextets and queues byte requests.
// ----------------------------------------------------------------------------
module b64dec_front
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire b64dec_pkg::b64_in_t       in_data,
    input  wire b64dec_pkg::b64_fifo_stat_t stat,
    output logic                           push,
    output b64dec_pkg::b64_job_t           job
);
    import b64dec_pkg::*;

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pad_reg, pad_next;

    b64_sextet_t sx;
    logic        take;
    logic        group;
    logic        accept;
    logic [17:0] acc_upd;
    logic [1:0]  cnt_upd;
    logic        pad_upd;

    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        sx      = char_decode(in_data.in_char);
        take    = !pad_reg && sx.hit;
        group   = take && (cnt_reg == 2'd3);
        pad_upd = pad_reg || (in_data.in_char == PAD_CHAR);
        acc_upd = acc_reg;
        cnt_upd = cnt_reg;
        if (group)
        begin
            acc_upd = '0;
            cnt_upd = '0;
        end
        else if (take)
        begin
            acc_upd = {acc_reg[11:0], sx.value};
            cnt_upd = cnt_reg + 2'd1;
        end

        job        = '0;
        job.eom    = in_data.end_of_input;
        if (group)
        begin
            job.bytes  = {acc_reg, sx.value};
            job.nbytes = 2'd3;
        end
        else if (in_data.end_of_input)
        begin
            // flush of a partial group; low pad bits dropped
            unique case (cnt_upd)
                2'd3:
                begin
                    job.bytes  = {acc_upd[17:2], 8'h00};
                    job.nbytes = 2'd2;
                end
                2'd2:
                begin
                    job.bytes  = {acc_upd[11:4], 16'h0000};
                    job.nbytes = 2'd1;
                end
                2'd1: job.err = 1'b1;
                default: job.err = 1'b0;
            endcase
        end

        push = accept && ((job.nbytes != 2'd0) || in_data.end_of_input);

        acc_next = acc_reg;
        cnt_next = cnt_reg;
        pad_next = pad_reg;
        if (accept)
        begin
            if (in_data.end_of_input)
            begin
                acc_next = '0;
                cnt_next = '0;
                pad_next = 1'b0;
            end
            else
            begin
                acc_next = acc_upd;
                cnt_next = cnt_upd;
                pad_next = pad_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            pad_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/b64dec_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64dec_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64dec_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire b64dec_pkg::b64_job_t   wr_job,
    input  wire logic                   pop,
    output b64dec_pkg::b64_job_t        rd_job,
    output b64dec_pkg::b64_fifo_stat_t  stat
);
    import b64dec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64_job_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == FULL_CNT);
    assign stat.empty = (cnt_reg == '0);
    assign rd_job     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/b64dec_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b64dec_back
// Expands queued requests into result items, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module b64dec_back
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire b64dec_pkg::b64_job_t      head,
    input  wire b64dec_pkg::b64_fifo_stat_t stat,
    output logic                           pop,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output b64dec_pkg::b64_out_t           out_data
);
    import b64dec_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    b64_out_t   out_data_reg, out_data_next;
    logic       load;
    logic       last;
    logic [7:0] sel;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        load = !stat.empty && (!out_valid_reg || out_ready);
        last = (head.nbytes == 2'd0) || (idx_reg == head.nbytes - 2'd1);
        unique case (idx_reg)
            2'd0:    sel = head.bytes[23:16];
            2'd1:    sel = head.bytes[15:8];
            default: sel = head.bytes[7:0];
        endcase

        out_data_next.byte_valid        = (head.nbytes != 2'd0);
        out_data_next.out_byte          = out_data_next.byte_valid ? sel : 8'h00;
        out_data_next.last_of_run       = last;
        out_data_next.end_of_message    = last && head.eom;
        out_data_next.lone_sextet_error = last && head.err;

        pop            = load && last;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/base64_decoder_top.sv =====
`default_nettype none
// A character that completes a group or ends the message passes through the
//   request queue and then the output register before its first result shows.
// Throughput: one character per cycle; a request expands to 1..3 results, sent
//   one per cycle when out_ready is high; input stalls only on a full queue.
// Reset: rst_n clears the sextet state, the queue pointers and output valid.
// ----------------------------------------------------------------------------
// base64_decoder_top
// Base64 decoder: a character classifier/packer in front, a request queue,
// and a result emitter behind it, each stalling on its own.
// ----------------------------------------------------------------------------
module base64_decoder_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire b64dec_pkg::b64_in_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output b64dec_pkg::b64_out_t      out_data
);
    import b64dec_pkg::*;

    // Front side: accepted alphabet characters before a pad update the sextet accumulator.
    // A request is queued when a group completes or the message ends.
    b64_job_t       wr_job;
    b64_job_t       rd_job;
    b64_fifo_stat_t stat;
    logic           push;
    logic           pop;

    b64dec_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .stat     (stat),
        .push     (push),
        .job      (wr_job)
    );

    // Queue absorbs bursts of three-byte requests while the output stalls.
    b64dec_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .stat   (stat)
    );

    // Back side: walks the head request one byte per cycle while the output is ready.
    b64dec_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (rd_job),
        .stat      (stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // No request is ever pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && stat.full))
        else $error("push into full request queue");

    // The back end never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && stat.empty))
        else $error("pop from empty request queue");

    // The end marker only rides on the last result of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.end_of_message) |-> out_data.last_of_run)
        else $error("end of message without last of run");

    // A lone-sextet error comes only on an end result that carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.lone_sextet_error)
            |-> (out_data.end_of_message && !out_data.byte_valid))
        else $error("lone sextet error on a data result");

endmodule
`default_nettype wire

// ===== test/tb_base64_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_decoder_top
// Self-checking bench for the base64 decoder. A driver feeds characters from a
// queue and a monitor decodes every accepted request in step with the DUT. It
// then checks each result field against the oldest decoded entry. The run
// covers four flow-control phases.
// ----------------------------------------------------------------------------
module tb_base64_decoder_top;

    import b64dec_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 8;       // settling margin after the last result
    localparam int PHASE_ITEMS  = 85;      // four phases, about 380 characters

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input is known from time zero
    // ------------------------------------------------------------------
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    b64_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    b64_out_t out_data;

    // Requests waiting for the driver, and decoded results waiting for the DUT
    b64_in_t  char_feed [$];
    b64_out_t decoded_q [$];

    // Decoder state mirrored by the bench
    logic [17:0] sextet_acc;
    logic [1:0]  sextet_cnt;
    logic        pad_hit;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   fail_count     = 0;
    int   cycle_count    = 0;
    logic req_taken      = 1'b0;

    base64_decoder_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Character map: -1 for anything outside the base64 alphabet
    // ------------------------------------------------------------------
    function automatic int sextet_of(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)           // 'A'..'Z'
            return int'(c) - 'h41;
        if (c >= 8'h61 && c <= 8'h7A)           // 'a'..'z'
            return int'(c) - 'h61 + int'(LOWER_BASE);
        if (c >= 8'h30 && c <= 8'h39)           // '0'..'9'
            return int'(c) - 'h30 + int'(DIGIT_BASE);
        if (c == PLUS_CHAR)
            return int'(PLUS_VALUE);
        if (c == SLASH_CHAR)
            return int'(SLASH_VALUE);
        return -1;
    endfunction

    // Inverse map, used to build well-formed random text
    function automatic logic [7:0] char_of(input int v);
        if (v < 26)
            return 8'(8'h41 + v);
        if (v < 52)
            return 8'(8'h61 + v - 26);
        if (v < 62)
            return 8'(8'h30 + v - 52);
        if (v == 62)
            return PLUS_CHAR;
        return SLASH_CHAR;
    endfunction

    function automatic void clear_decoder();
        sextet_acc = '0;
        sextet_cnt = '0;
        pad_hit    = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Decode one accepted request and queue the results it must cause.
    // Up to three results; the last one of the request carries last_of_run,
    // and on the end item the last also carries the end-of-message flags.
    // ------------------------------------------------------------------
    task automatic decode_request(input b64_in_t req);
        b64_out_t    res [3];
        int          n;
        int          sx;
        logic [5:0]  sext;
        logic [23:0] grp;
        logic        lone;
        n    = 0;
        lone = 1'b0;
        for (int i = 0; i < 3; i++)
            res[i] = '0;
        // After a pad everything is ignored up to the end of the message,
        // a second pad included
        if (!pad_hit)
        begin
            if (req.in_char == PAD_CHAR)
                pad_hit = 1'b1;
            else
            begin
                sx = sextet_of(req.in_char);
                if (sx >= 0)
                begin
                    sext = sx[5:0];
                    if (sextet_cnt == 2'd3)
                    begin
                        // Fourth sextet closes the group: three bytes, MSB first
                        grp = {sextet_acc, sext};
                        res[0].out_byte = grp[23:16];
                        res[1].out_byte = grp[15:8];
                        res[2].out_byte = grp[7:0];
                        res[0].byte_valid = 1'b1;
                        res[1].byte_valid = 1'b1;
                        res[2].byte_valid = 1'b1;
                        n = 3;
                        sextet_acc = '0;
                        sextet_cnt = '0;
                    end
                    else
                    begin
                        sextet_acc = {sextet_acc[11:0], sext};
                        sextet_cnt = sextet_cnt + 2'd1;
                    end
                end
            end
        end
        // The character of the end item has been handled; now flush.
        // A full group on the end item leaves nothing pending here.
        if (req.end_of_input)
        begin
            case (sextet_cnt)
                2'd3:
                begin
                    res[n].out_byte     = sextet_acc[17:10];
                    res[n].byte_valid   = 1'b1;
                    res[n+1].out_byte   = sextet_acc[9:2];
                    res[n+1].byte_valid = 1'b1;
                    n = n + 2;
                end
                2'd2:
                begin
                    res[n].out_byte   = sextet_acc[11:4];
                    res[n].byte_valid = 1'b1;
                    n = n + 1;
                end
                2'd1:
                    lone = 1'b1;   // a lone sextet is dropped and flagged
                default:
                    ;
            endcase
            // Nothing to emit still gives one empty result to close the message
            if (n == 0)
                n = 1;
            res[n-1].end_of_message    = 1'b1;
            res[n-1].lone_sextet_error = lone;
            clear_decoder();
        end
        if (n > 0)
            res[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            decoded_q.push_back(res[i]);
    endtask

    task automatic compare_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
            fail_count++;
        end
    endtask

    task automatic check_result(input b64_out_t got);
        b64_out_t exp_r;
        if (decoded_q.size() == 0)
        begin
            $display("%0t: result with none expected, expected none, actual %h", $time, got);
            fail_count++;
        end
        else
        begin
            exp_r = decoded_q.pop_front();
            compare_field("out_byte", exp_r.out_byte, got.out_byte);
            compare_field("byte_valid", exp_r.byte_valid, got.byte_valid);
            compare_field("last_of_run", exp_r.last_of_run, got.last_of_run);
            compare_field("end_of_message", exp_r.end_of_message, got.end_of_message);
            compare_field("lone_sextet_error", exp_r.lone_sextet_error,
                          got.lone_sextet_error);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. A request stays up with
    // its payload until the rising edge that accepts it.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                if (char_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_data  <= char_feed.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both handshakes on the rising edge. Decoding comes
    // before checking; a request never produces a result in its own cycle.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                decode_request(in_data);
            if (out_valid && out_ready)
                check_result(out_data);
        end
        else
        begin
            req_taken <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_char(input logic [7:0] c, input logic last);
        b64_in_t req;
        req.in_char      = c;
        req.end_of_input = last;
        char_feed.push_back(req);
    endtask

    task automatic queue_text(input string text);
        for (int i = 0; i < text.len(); i++)
            queue_char(text[i], i == text.len() - 1);
    endtask

    // Mostly alphabet characters, some pads, some arbitrary bytes (noise).
    // Short messages dominate; a few longer ones carry several groups.
    task automatic queue_random_message(output int len);
        int roll;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                queue_char(char_of($urandom_range(0, 63)), i == len - 1);
            else if (roll < 86)
                queue_char(PAD_CHAR, i == len - 1);
            else
                queue_char(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Sender holds off until the feed is empty and every result has come,
    // then lets the pipeline settle.
    task automatic wait_drained();
        while (char_feed.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int len;
        int phase_items;
        clear_decoder();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every letter/digit/symbol range edge, full group on the
        // end item, pad followed by more text and a second pad, flushes of
        // two and one bytes, lone sextet behind skipped bytes, pad-only message
        queue_text("AZaz09+/");
        queue_text("TWE=Q=");
        queue_text("TQ==");
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(8'h51, 1'b1);      // 'Q' alone at the end
        queue_char(PAD_CHAR, 1'b1);
        wait_drained();

        // Random phases; each boundary is also a full pause of the sender
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                queue_random_message(len);
                phase_items += len;
            end
            wait_drained();
        end

        if (fail_count == 0 && decoded_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
